### rtl/core/sem_pkg.sv
// ---------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths and constants for the RGB Sobel core.
// ---------------------------------------------------------------------------
package sem_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = 12;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
endpackage

### rtl/core/sem_root.sv
// ---------------------------------------------------------------------------
// Rounded root unit
// Computes round(sqrt(gx^2+gy^2)) saturated at 255 for one channel, in
// nine pipeline stages: one square stage and eight restoring root steps.
// ---------------------------------------------------------------------------
module sem_root import sem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic signed [11:0] gx,
    input  logic signed [11:0] gy,
    output logic [7:0]        mag
);
    logic [21:0] s_reg [0:8];
    logic [8:0]  n_reg [0:8];
    logic        sat_reg [0:8];
    logic signed [21:0] gx_w, gy_w;
    logic [21:0] sum_next;
    logic [8:0]  t_next [1:8];
    logic [8:0]  fin;

    assign gx_w = 22'(gx);
    assign gy_w = 22'(gy);
    assign sum_next = gx_w * gx_w + gy_w * gy_w;

    always_comb
    begin
        for (int k = 1; k <= 8; k++)
            t_next[k] = n_reg[k-1] | (9'd1 << (8 - k));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= 8; k++)
            begin
                s_reg[k] <= '0;
                n_reg[k] <= '0;
                sat_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s_reg[0] <= sum_next;
            n_reg[0] <= '0;
            sat_reg[0] <= (sum_next >= 22'd65281);
            for (int k = 1; k <= 8; k++)
            begin
                s_reg[k] <= s_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                n_reg[k] <= ((22'(t_next[k]) * 22'(t_next[k])) <= s_reg[k-1]) ?
                            t_next[k] : n_reg[k-1];
            end
        end
    end

    always_comb
    begin
        fin = n_reg[8];
        if (s_reg[8] > (22'(fin) * 22'(fin)) + 22'(fin))
            fin = fin + 9'd1;
        if (sat_reg[8] || fin > 9'd255)
            mag = 8'd255;
        else
            mag = fin[7:0];
    end
endmodule

### rtl/core/sobel_edge_magnitude_rgb_core.sv
// ---------------------------------------------------------------------------
// Sobel edge magnitude RGB core
// Streaming 3x3 Sobel magnitude on RGB pixels with two line stores.
// ---------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (valid/stall). Each
// input word produces zero, one or two result words on the output channel;
// a result for pixel (i-1,j-1) follows input (i,j), and the last column of a
// row yields an extra result for the right edge. After each frame the source
// sends one row of flush words to drain the bottom row of results.
// The two line stores live in one memory of 48-bit rows, read into a
// register on acceptance and written back in S_READ (read-modify-write).
// One input word is processed at a time: a word is accepted, its line row
// is read, the window shifts, and each result passes the nine-stage root
// pipeline. Each result adds staging, root pipeline and output load. The
// input stalls while a word is in flight and during a configuration write.
// Reset clears the window, position and control state; memory contents are
// undefined until written and are masked above the top of the frame. When
// the receiver stalls, the result is held in the output register and the
// sequencer waits. Configuration writes restart the position at row zero.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_core import sem_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [CW-1:0] cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    blue_in,
    input  logic [7:0]    green_in,
    input  logic [7:0]    red_in,
    input  logic          flush,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    blue_out,
    output logic [7:0]    green_out,
    output logic [7:0]    red_out,
    output logic          end_of_frame,
    output logic          last_of_run
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_CALC = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    logic [CW-1:0] width_reg, height_reg;
    logic [AW:0]   col_reg;
    logic [HW-1:0] row_reg;
    logic [23:0]   win_reg [0:2][0:2];
    logic [47:0]   line_mem [0:MAX_WIDTH-1];
    logic [47:0]   rd_reg;
    logic [23:0]   bot_reg;
    logic [AW-1:0] addr_reg;
    logic [AW:0]   j_reg;
    logic [HW-1:0] i_reg;
    logic [1:0]    pend_reg;   // results still to start
    logic          second_reg; // second result is being computed
    logic [3:0]    cnt_reg;
    logic [23:0]   p_reg [0:2][0:2];
    logic          eof_reg, last_reg;
    logic          ovalid_reg;

    logic [AW:0]   w_eff, j_c;
    logic [HW-1:0] h_eff, i_c;
    logic [23:0]   top_c, mid_c;
    logic signed [11:0] gx_c [0:2];
    logic signed [11:0] gy_c [0:2];
    logic [7:0]    mag_c [0:2];
    logic          run_c;
    logic          emit1_c, emit2_c;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = (AW+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (AW+1)'(MAX_WIDTH);
        else
            w_eff = (AW+1)'(width_reg);
        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
        j_c = (col_reg >= w_eff) ? w_eff - 1'b1 : col_reg;
        i_c = (row_reg > h_eff) ? h_eff : row_reg;
    end

    assign in_stall = (state_reg != S_IDLE) || cfg_we;
    assign top_c = (i_reg >= HW'(2)) ? rd_reg[47:24] : 24'd0;
    assign mid_c = (i_reg >= HW'(1)) ? rd_reg[23:0] : 24'd0;
    assign emit1_c = (i_reg >= HW'(1)) && (j_reg >= (AW+1)'(1));
    assign emit2_c = (i_reg >= HW'(1)) && (j_reg == w_eff - 1'b1);

    // Gradients from the staged masked window, one per channel.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic signed [11:0] v [0:2][0:2];
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    v[r][c] = 12'(p_reg[r][c][8*ch +: 8]);
            gx_c[ch] = (v[0][2] - v[0][0]) + 12'(2) * (v[1][2] - v[1][0])
                     + (v[2][2] - v[2][0]);
            gy_c[ch] = (v[2][0] - v[0][0]) + 12'(2) * (v[2][1] - v[0][1])
                     + (v[2][2] - v[0][2]);
        end
    end

    assign run_c = (state_reg == S_WAIT);

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_root
        sem_root u_root (
            .clk (clk),
            .rst_n (rst_n),
            .en  (run_c),
            .gx  (gx_c[ch]),
            .gy  (gy_c[ch]),
            .mag (mag_c[ch])
        );
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            rd_reg <= line_mem[j_c[AW-1:0]];
        if (state_reg == S_READ)
            line_mem[addr_reg] <= {rd_reg[23:0], bot_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            width_reg  <= CW'(640);
            height_reg <= CW'(480);
            col_reg    <= '0;
            row_reg    <= '0;
            ovalid_reg <= 1'b0;
            pend_reg   <= '0;
            second_reg <= 1'b0;
            cnt_reg    <= '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            // In S_OUT the output register is reloaded below instead.
            if (ovalid_reg && !out_stall && state_reg != S_OUT)
                ovalid_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
                col_reg <= '0;
                row_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !cfg_we)
                    begin
                        j_reg <= j_c;
                        i_reg <= i_c;
                        addr_reg <= j_c[AW-1:0];
                        bot_reg <= (i_c < h_eff && !flush) ?
                                   {red_in, green_in, blue_in} : 24'd0;
                        if (j_c + 1'b1 >= w_eff)
                        begin
                            col_reg <= '0;
                            row_reg <= (i_c + 1'b1 > h_eff) ? '0 : i_c + 1'b1;
                        end
                        else
                        begin
                            col_reg <= j_c + 1'b1;
                            row_reg <= i_c;
                        end
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= top_c;
                    win_reg[1][2] <= mid_c;
                    win_reg[2][2] <= bot_reg;
                    pend_reg <= {emit2_c, emit1_c};
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (pend_reg == 2'b00)
                        state_reg <= S_IDLE;
                    else
                    begin
                        second_reg <= !pend_reg[0];
                        for (int r = 0; r < 3; r++)
                        begin
                            if (pend_reg[0])
                            begin
                                p_reg[r][0] <= (j_reg >= (AW+1)'(2)) ?
                                               win_reg[r][0] : 24'd0;
                                p_reg[r][1] <= win_reg[r][1];
                                p_reg[r][2] <= win_reg[r][2];
                            end
                            else
                            begin
                                p_reg[r][0] <= (j_reg >= (AW+1)'(1)) ?
                                               win_reg[r][1] : 24'd0;
                                p_reg[r][1] <= win_reg[r][2];
                                p_reg[r][2] <= 24'd0;
                            end
                        end
                        cnt_reg <= '0;
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd8)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || !out_stall)
                    begin
                        ovalid_reg <= 1'b1;
                        blue_out  <= mag_c[0];
                        green_out <= mag_c[1];
                        red_out   <= mag_c[2];
                        eof_reg   <= second_reg && (i_reg == h_eff);
                        last_reg  <= second_reg || !pend_reg[1];
                        if (second_reg)
                            pend_reg <= 2'b00;
                        else
                            pend_reg <= {pend_reg[1], 1'b0};
                        state_reg <= S_CALC;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ovalid_reg;
    assign end_of_frame = eof_reg;
    assign last_of_run = last_reg;
endmodule
